/* rtl/dnsx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsx_pkg
// Shared types and constants for the DNS answer record extractor.
// ----------------------------------------------------------------------------
package dnsx_pkg;

  // message size limit, bytes at or past this position are not parsed
  localparam int MAX_MESSAGE_BYTES = 4096;
  localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

  // header layout
  localparam int HDR_FLAGS_HI = 2;
  localparam int HDR_FLAGS_LO = 3;
  localparam int HDR_COUNT_HI = 6;
  localparam int HDR_COUNT_LO = 7;
  localparam int QUESTION_FIXED_BYTES = 18;
  localparam int START_W = 9;

  // answer record fixed part, offsets from the name pointer
  localparam int OFF_W = 4;
  localparam int OFF_TYPE_HI = 2;
  localparam int OFF_TYPE_LO = 3;
  localparam int OFF_TTL_FIRST = 6;
  localparam int OFF_TTL_LAST = 9;
  localparam int OFF_LEN_HI = 10;
  localparam int OFF_LEN_LO = 11;

  // record types
  localparam logic [15:0] TYPE_A = 16'd1;
  localparam logic [15:0] TYPE_AAAA = 16'd28;
  localparam logic [15:0] TYPE_SOA = 16'd6;

  // address lengths in bytes
  localparam logic [15:0] A_ADDR_BYTES = 16'd4;
  localparam logic [15:0] AAAA_ADDR_BYTES = 16'd16;

  // result kinds
  localparam logic [2:0] KIND_A = 3'd0;
  localparam logic [2:0] KIND_AAAA = 3'd1;
  localparam logic [2:0] KIND_SOA = 3'd2;
  localparam logic [2:0] KIND_END = 3'd3;
  localparam logic [2:0] KIND_TRUNC = 3'd4;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_FIXED,
    PH_ADDR,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] time_to_live;
    logic [63:0] address_upper;
    logic [63:0] address_lower;
    logic [15:0] message_flags;
    logic [15:0] answer_count;
    logic        last_result;
  } result_t;

  // up to two results written per accepted byte, slot 1 only with slot 0
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t data0;
    result_t data1;
  } push_t;

endpackage

/* rtl/dnsx_byte_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsx_byte_if
// Message byte channel: valid/ready handshake with one byte per transaction.
// ----------------------------------------------------------------------------
interface dnsx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

/* rtl/dnsx_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsx_result_if
// Result channel: valid/ready handshake with one extracted result per transaction.
// ----------------------------------------------------------------------------
interface dnsx_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [31:0] time_to_live;
  logic [63:0] address_upper;
  logic [63:0] address_lower;
  logic [15:0] message_flags;
  logic [15:0] answer_count;
  logic        last_result;

  modport source (
    output valid, output result_kind, output time_to_live, output address_upper,
    output address_lower, output message_flags, output answer_count,
    output last_result, input ready
  );
  modport sink (
    input valid, input result_kind, input time_to_live, input address_upper,
    input address_lower, input message_flags, input answer_count,
    input last_result, output ready
  );
endinterface

/* rtl/dnsx_res_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsx_res_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module dnsx_res_fifo (
  input  logic             clk,
  input  logic             rst,
  input  dnsx_pkg::push_t  push,
  output logic             room_for_two,
  output logic             out_valid,
  input  logic             out_ready,
  output dnsx_pkg::result_t out_data
);
  import dnsx_pkg::*;

  result_t               entries [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wr_ptr;
  logic [RQ_PTR_W-1:0]   rd_ptr;
  logic [RQ_CNT_W-1:0]   count;
  logic [RQ_CNT_W-1:0]   count_next;
  logic [RQ_PTR_W-1:0]   wr_ptr_next;
  logic [RQ_CNT_W-1:0]   push_n;
  logic                  pop;

  // occupancy and handshake
  assign pop          = out_valid && out_ready;
  assign out_valid    = (count != '0);
  assign out_data     = entries[rd_ptr];
  assign room_for_two = (count <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign push_n       = RQ_CNT_W'(push.valid0) + RQ_CNT_W'(push.valid1);
  assign count_next   = count + push_n - RQ_CNT_W'(pop);
  assign wr_ptr_next  = wr_ptr + RQ_PTR_W'(push_n);

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr + RQ_PTR_W'(pop);
      count  <= count_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid0) begin
      entries[wr_ptr] <= push.data0;
    end
    if (push.valid1) begin
      entries[wr_ptr + RQ_PTR_W'(1)] <= push.data1;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue count past depth");

  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    push.valid1 |-> push.valid0)
    else $error("second result pushed without first");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !rst |=> count == $past(count) + $past(push_n) - RQ_CNT_W'($past(pop)))
    else $error("result queue count out of step");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push.valid0 |-> count + push_n <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue overfilled");

endmodule

/* rtl/dns_answer_record_extractor_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_answer_record_extractor_core
// Walks a DNS response one byte per transaction, captures the header flags
// and answer count, and reports A/AAAA records, SOA stops, truncated records
// and the end of each message.
// ----------------------------------------------------------------------------
//   channel      dir  transaction
//   byte_in      in   one message byte plus last_byte mark
//   result_out   out  one result: kind, ttl, address, flags, count, last
//   cfg_wr_*     in   query_name_length write, no handshake
//
// One byte is accepted per cycle; its state update and results are formed in
// the cycle it is accepted and land in a four-entry result queue.
// A byte yields at most two results (a record or truncation, then the end of
// message); the output side moves one per cycle.
// byte_in.ready drops while the queue has fewer than two free entries.
// Synchronous reset clears all parse state and the queue; the last byte of a
// message returns parse state to reset without touching query_name_length.
// ----------------------------------------------------------------------------
module dns_answer_record_extractor_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  dnsx_byte_if.sink byte_in,
  dnsx_result_if.source result_out
);
  import dnsx_pkg::*;

  // configuration
  logic [7:0] query_name_length;

  // parse state
  logic [POS_W-1:0] byte_position, byte_position_next;
  phase_t           parse_phase, parse_phase_next;
  logic [OFF_W-1:0] record_offset, record_offset_next;
  logic [15:0]      record_type_word, record_type_word_next;
  logic [31:0]      ttl_shift, ttl_shift_next;
  logic [15:0]      data_length, data_length_next;
  logic [63:0]      address_shift_upper, address_shift_upper_next;
  logic [63:0]      address_shift_lower, address_shift_lower_next;
  logic [15:0]      flags_copy, flags_copy_next;
  logic [15:0]      count_copy, count_copy_next;
  logic             stopped, stopped_next;

  // working signals
  logic             accept;
  logic             parse_en;
  logic [7:0]       b;
  logic [START_W-1:0] answer_start;
  logic [15:0]      type_cur;
  logic [15:0]      dlen_cur;
  logic [15:0]      dlen_dec;
  logic             rec_valid;
  result_t          rec_res;
  result_t          trunc_res;
  result_t          end_res;
  logic             open_rec;
  push_t            push;
  logic             room_for_two;
  result_t          out_data;

  assign accept       = byte_in.valid && byte_in.ready;
  assign byte_in.ready = room_for_two;
  assign b            = byte_in.byte_value;
  assign parse_en     = !stopped && (byte_position < POS_W'(MAX_MESSAGE_BYTES));
  assign answer_start = START_W'(QUESTION_FIXED_BYTES) + START_W'(query_name_length);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      query_name_length <= '0;
    end else if (cfg_wr_en) begin
      query_name_length <= cfg_wr_data;
    end
  end

  // next parse state and results for the accepted byte
  always_comb begin
    byte_position_next       = byte_position;
    parse_phase_next         = parse_phase;
    record_offset_next       = record_offset;
    record_type_word_next    = record_type_word;
    ttl_shift_next           = ttl_shift;
    data_length_next         = data_length;
    address_shift_upper_next = address_shift_upper;
    address_shift_lower_next = address_shift_lower;
    flags_copy_next          = flags_copy;
    count_copy_next          = count_copy;
    stopped_next             = stopped;
    rec_valid                = 1'b0;
    rec_res                  = '0;
    type_cur                 = record_type_word;
    dlen_cur                 = data_length;
    dlen_dec                 = data_length - 16'd1;

    if (parse_en) begin
      byte_position_next = byte_position + POS_W'(1);
      case (parse_phase)
        PH_HEADER: begin
          if (byte_position == POS_W'(HDR_FLAGS_HI) ||
              byte_position == POS_W'(HDR_FLAGS_LO)) begin
            flags_copy_next = {flags_copy[7:0], b};
          end else if (byte_position == POS_W'(HDR_COUNT_HI) ||
                       byte_position == POS_W'(HDR_COUNT_LO)) begin
            count_copy_next = {count_copy[7:0], b};
          end
          if ((POS_W+1)'(byte_position) + (POS_W+1)'(1) >=
              (POS_W+1)'(answer_start)) begin
            parse_phase_next   = PH_FIXED;
            record_offset_next = '0;
          end
        end
        PH_FIXED: begin
          if (record_offset == OFF_W'(OFF_TYPE_HI) ||
              record_offset == OFF_W'(OFF_TYPE_LO)) begin
            type_cur              = {record_type_word[7:0], b};
            record_type_word_next = type_cur;
          end else if (record_offset >= OFF_W'(OFF_TTL_FIRST) &&
                       record_offset <= OFF_W'(OFF_TTL_LAST)) begin
            ttl_shift_next = {ttl_shift[23:0], b};
          end else if (record_offset == OFF_W'(OFF_LEN_HI) ||
                       record_offset == OFF_W'(OFF_LEN_LO)) begin
            dlen_cur         = {data_length[7:0], b};
            data_length_next = dlen_cur;
          end

          if (record_offset == OFF_W'(OFF_TYPE_LO) && type_cur == TYPE_SOA) begin
            // start of authority: no address, ignore the rest
            rec_valid             = 1'b1;
            rec_res.result_kind   = KIND_SOA;
            stopped_next          = 1'b1;
          end else if (record_offset == OFF_W'(OFF_LEN_LO)) begin
            record_offset_next = '0;
            if (type_cur == TYPE_A || type_cur == TYPE_AAAA) begin
              data_length_next         = (type_cur == TYPE_A) ? A_ADDR_BYTES
                                                              : AAAA_ADDR_BYTES;
              address_shift_upper_next = '0;
              address_shift_lower_next = '0;
              parse_phase_next         = PH_ADDR;
            end else if (dlen_cur != 16'd0) begin
              parse_phase_next = PH_SKIP;
            end
          end else begin
            record_offset_next = record_offset + OFF_W'(1);
          end
        end
        PH_ADDR: begin
          address_shift_upper_next = {address_shift_upper[55:0],
                                      address_shift_lower[63:56]};
          address_shift_lower_next = {address_shift_lower[55:0], b};
          data_length_next         = dlen_dec;
          if (dlen_dec == 16'd0) begin
            rec_valid             = 1'b1;
            rec_res.result_kind   = (record_type_word == TYPE_A) ? KIND_A : KIND_AAAA;
            rec_res.time_to_live  = ttl_shift;
            rec_res.address_upper = address_shift_upper_next;
            rec_res.address_lower = address_shift_lower_next;
            parse_phase_next      = PH_FIXED;
            record_offset_next    = '0;
          end
        end
        PH_SKIP: begin
          data_length_next = dlen_dec;
          if (dlen_dec == 16'd0) begin
            parse_phase_next   = PH_FIXED;
            record_offset_next = '0;
          end
        end
        default: begin
          parse_phase_next = PH_HEADER;
        end
      endcase
    end

    // end of message results
    open_rec = (parse_phase_next != PH_HEADER) &&
               ((parse_phase_next != PH_FIXED) || (record_offset_next != '0));
    trunc_res             = '0;
    trunc_res.result_kind = KIND_TRUNC;
    end_res               = '0;
    end_res.result_kind   = KIND_END;
    end_res.message_flags = flags_copy_next;
    end_res.answer_count  = count_copy_next;
    end_res.last_result   = 1'b1;

    push = '0;
    if (accept) begin
      if (byte_in.last_byte) begin
        if (rec_valid) begin
          push.valid0 = 1'b1;
          push.data0  = rec_res;
          push.valid1 = 1'b1;
          push.data1  = end_res;
        end else if (!stopped_next && open_rec) begin
          push.valid0 = 1'b1;
          push.data0  = trunc_res;
          push.valid1 = 1'b1;
          push.data1  = end_res;
        end else begin
          push.valid0 = 1'b1;
          push.data0  = end_res;
        end
      end else if (rec_valid) begin
        push.valid0 = 1'b1;
        push.data0  = rec_res;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst || (accept && byte_in.last_byte)) begin
      byte_position       <= '0;
      parse_phase         <= PH_HEADER;
      record_offset       <= '0;
      record_type_word    <= '0;
      ttl_shift           <= '0;
      data_length         <= '0;
      address_shift_upper <= '0;
      address_shift_lower <= '0;
      flags_copy          <= '0;
      count_copy          <= '0;
      stopped             <= 1'b0;
    end else if (accept) begin
      byte_position       <= byte_position_next;
      parse_phase         <= parse_phase_next;
      record_offset       <= record_offset_next;
      record_type_word    <= record_type_word_next;
      ttl_shift           <= ttl_shift_next;
      data_length         <= data_length_next;
      address_shift_upper <= address_shift_upper_next;
      address_shift_lower <= address_shift_lower_next;
      flags_copy          <= flags_copy_next;
      count_copy          <= count_copy_next;
      stopped             <= stopped_next;
    end
  end

  // result queue
  dnsx_res_fifo u_res_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room_for_two (room_for_two),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .out_data     (out_data)
  );

  assign result_out.result_kind   = out_data.result_kind;
  assign result_out.time_to_live  = out_data.time_to_live;
  assign result_out.address_upper = out_data.address_upper;
  assign result_out.address_lower = out_data.address_lower;
  assign result_out.message_flags = out_data.message_flags;
  assign result_out.answer_count  = out_data.answer_count;
  assign result_out.last_result   = out_data.last_result;

  // checks
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (result_out.last_result == (result_out.result_kind == KIND_END)))
    else $error("last_result not tied to end of message");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && byte_in.last_byte |=> parse_phase == PH_HEADER && byte_position == '0
                                    && !stopped)
    else $error("parse state not cleared after last byte");

  a_stop_in_fixed: assert property (@(posedge clk) disable iff (rst)
    stopped |-> parse_phase == PH_FIXED && record_offset == OFF_W'(OFF_TYPE_LO))
    else $error("stop outside record type field");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_W'(MAX_MESSAGE_BYTES))
    else $error("byte position past message limit");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DNS answer record extractor. DNS response
// messages are built byte by byte and sent through the byte channel, with
// random sender gaps and random receiver stalls. A parse model inside the
// bench predicts every result. Each result transaction is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import dnsx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 1150;
  localparam int MAX_GAP = 19;
  // an ordinary record type that is only skipped
  localparam logic [15:0] TYPE_NS = 16'd2;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;

  dnsx_byte_if byte_ch ();
  dnsx_result_if result_ch ();

  dns_answer_record_extractor_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .byte_in(byte_ch),
    .result_out(result_ch)
  );

  always #5 clk = ~clk;

  // run control
  int src_gap_max = 0;
  int sink_gap_max = 0;
  int hold_request = 0;
  int fail_count = 0;
  int sent_bytes = 0;
  int unsigned cycle_count = 0;

  // parse model state
  logic [7:0] qname_len_m;
  logic [15:0] msg_pos;
  phase_t msg_phase;
  logic [15:0] rec_off;
  logic [15:0] rec_type;
  logic [31:0] rec_ttl;
  logic [15:0] rec_len;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [15:0] hdr_flags;
  logic [15:0] hdr_count;
  logic soa_halt;

  result_t expected_results[$];
  logic [7:0] msg_q[$];

  // ---------------------------------------------------------------------------
  // parse model
  // ---------------------------------------------------------------------------
  function automatic void push_result(input logic [2:0] kind, input logic [31:0] ttl,
                                      input logic [63:0] hi, input logic [63:0] lo,
                                      input logic [15:0] flags, input logic [15:0] count,
                                      input logic is_last);
    result_t r;
    r.result_kind = kind;
    r.time_to_live = ttl;
    r.address_upper = hi;
    r.address_lower = lo;
    r.message_flags = flags;
    r.answer_count = count;
    r.last_result = is_last;
    expected_results = {expected_results, r};
  endfunction

  function automatic void clear_parse_state();
    msg_pos = '0;
    msg_phase = PH_HEADER;
    rec_off = '0;
    rec_type = '0;
    rec_ttl = '0;
    rec_len = '0;
    addr_hi = '0;
    addr_lo = '0;
    hdr_flags = '0;
    hdr_count = '0;
    soa_halt = 1'b0;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic is_last);
    int answer_start;
    logic rec_open;
    if (!soa_halt && msg_pos < MAX_MESSAGE_BYTES) begin
      case (msg_phase)
        PH_HEADER: begin
          answer_start = QUESTION_FIXED_BYTES + qname_len_m;
          if (msg_pos == HDR_FLAGS_HI || msg_pos == HDR_FLAGS_LO)
            hdr_flags = {hdr_flags[7:0], b};
          else if (msg_pos == HDR_COUNT_HI || msg_pos == HDR_COUNT_LO)
            hdr_count = {hdr_count[7:0], b};
          if (msg_pos + 1 >= answer_start) begin
            msg_phase = PH_FIXED;
            rec_off = '0;
          end
        end
        PH_FIXED: begin
          if (rec_off == OFF_TYPE_HI || rec_off == OFF_TYPE_LO)
            rec_type = {rec_type[7:0], b};
          else if (rec_off >= OFF_TTL_FIRST && rec_off <= OFF_TTL_LAST)
            rec_ttl = {rec_ttl[23:0], b};
          else if (rec_off == OFF_LEN_HI || rec_off == OFF_LEN_LO)
            rec_len = {rec_len[7:0], b};
          // soa stops the walk for the rest of the message
          if (rec_off == OFF_TYPE_LO && rec_type == TYPE_SOA) begin
            push_result(KIND_SOA, '0, '0, '0, '0, '0, 1'b0);
            soa_halt = 1'b1;
          end else if (rec_off == OFF_LEN_LO) begin
            rec_off = '0;
            if (rec_type == TYPE_A || rec_type == TYPE_AAAA) begin
              rec_len = (rec_type == TYPE_A) ? A_ADDR_BYTES : AAAA_ADDR_BYTES;
              addr_hi = '0;
              addr_lo = '0;
              msg_phase = PH_ADDR;
            end else if (rec_len != 0) begin
              msg_phase = PH_SKIP;
            end
          end else begin
            rec_off = rec_off + 1'b1;
          end
        end
        PH_ADDR: begin
          addr_hi = {addr_hi[55:0], addr_lo[63:56]};
          addr_lo = {addr_lo[55:0], b};
          rec_len = rec_len - 1'b1;
          if (rec_len == 0) begin
            push_result((rec_type == TYPE_A) ? KIND_A : KIND_AAAA, rec_ttl, addr_hi,
                        addr_lo, '0, '0, 1'b0);
            msg_phase = PH_FIXED;
            rec_off = '0;
          end
        end
        default: begin
          rec_len = rec_len - 1'b1;
          if (rec_len == 0) begin
            msg_phase = PH_FIXED;
            rec_off = '0;
          end
        end
      endcase
      msg_pos = msg_pos + 1'b1;
    end
    // end of message, with a truncation report for an open record
    if (is_last) begin
      rec_open = (msg_phase != PH_HEADER) && (msg_phase != PH_FIXED || rec_off != 0);
      if (!soa_halt && rec_open)
        push_result(KIND_TRUNC, '0, '0, '0, '0, '0, 1'b0);
      push_result(KIND_END, '0, '0, '0, hdr_flags, hdr_count, 1'b1);
      clear_parse_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // message building
  // ---------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] v);
    msg_q = {msg_q, v};
  endfunction

  function automatic void add_header(input logic [15:0] flags, input logic [15:0] count);
    int answer_start;
    answer_start = QUESTION_FIXED_BYTES + qname_len_m;
    for (int i = 0; i < answer_start; i++) begin
      case (i)
        HDR_FLAGS_HI: add_byte(flags[15:8]);
        HDR_FLAGS_LO: add_byte(flags[7:0]);
        HDR_COUNT_HI: add_byte(count[15:8]);
        HDR_COUNT_LO: add_byte(count[7:0]);
        default: add_byte(8'($urandom));
      endcase
    end
  endfunction

  // fill below zero gives random data bytes
  function automatic void add_record(input logic [15:0] rtype, input logic [31:0] ttl,
                                     input logic [15:0] dlen, input int data_bytes,
                                     input int fill);
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    add_byte(rtype[15:8]);
    add_byte(rtype[7:0]);
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    for (int i = 3; i >= 0; i--)
      add_byte(ttl[8*i +: 8]);
    add_byte(dlen[15:8]);
    add_byte(dlen[7:0]);
    repeat (data_bytes) add_byte((fill < 0) ? 8'($urandom) : 8'(fill));
  endfunction

  function automatic void add_random_record();
    int pick;
    int n;
    logic [15:0] t;
    pick = $urandom_range(99, 0);
    n = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 0);
    if (pick < 40) begin
      add_record(TYPE_A, $urandom, 16'($urandom), int'(A_ADDR_BYTES), -1);
    end else if (pick < 70) begin
      add_record(TYPE_AAAA, $urandom, 16'($urandom), int'(AAAA_ADDR_BYTES), -1);
    end else if (pick < 75) begin
      add_record(TYPE_SOA, $urandom, n[15:0], n, -1);
    end else begin
      t = 16'($urandom);
      if (t == TYPE_A || t == TYPE_AAAA || t == TYPE_SOA)
        t = TYPE_NS;
      add_record(t, $urandom, n[15:0], n, -1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // byte channel driver
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = $urandom_range(src_gap_max, 0);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.byte_value <= b;
    byte_ch.last_byte <= is_last;
    @(posedge clk);
    while (byte_ch.ready !== 1'b1) @(posedge clk);
    sent_bytes++;
    predict_byte(b, is_last);
  endtask

  task automatic send_span(input int first_idx, input int end_idx, input bit close_msg);
    for (int i = first_idx; i < end_idx; i++)
      send_byte(msg_q[i], close_msg && (i == end_idx - 1));
  endtask

  task automatic send_message(input int n);
    send_span(0, n, 1'b1);
  endtask

  // stop offering bytes until every predicted result is back
  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_query_len(input logic [7:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    qname_len_m = v;
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    result_t got;
    result_t want;
    got.result_kind = result_ch.result_kind;
    got.time_to_live = result_ch.time_to_live;
    got.address_upper = result_ch.address_upper;
    got.address_lower = result_ch.address_lower;
    got.message_flags = result_ch.message_flags;
    got.answer_count = result_ch.answer_count;
    got.last_result = result_ch.last_result;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      compare_field("time_to_live", 64'(want.time_to_live), 64'(got.time_to_live));
      compare_field("address_upper", want.address_upper, got.address_upper);
      compare_field("address_lower", want.address_lower, got.address_lower);
      compare_field("message_flags", 64'(want.message_flags), 64'(got.message_flags));
      compare_field("answer_count", 64'(want.answer_count), 64'(got.answer_count));
      compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
    end
  endfunction

  // result receiver: random stalls per transaction, long hold-off on request
  initial begin : result_sink
    int gap_left;
    int hold_left;
    gap_left = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        check_result();
        gap_left = $urandom_range(sink_gap_max, 0);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // run timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // messages that end in the header or before the answer section, then a record after the longest question
  task automatic test_short_messages();
    write_query_len(8'd0);
    src_gap_max = MAX_GAP;
    sink_gap_max = MAX_GAP;
    msg_q.delete();
    add_header(16'hFFFF, 16'hFFFF);
    send_message(1);
    send_message(4);
    send_message(7);
    send_message(msg_q.size());
    msg_q.delete();
    add_header(16'h0000, 16'h0000);
    send_message(msg_q.size());
    // longest question section
    write_query_len(8'd253);
    msg_q.delete();
    add_header(16'h8180, 16'h0001);
    add_record(TYPE_A, $urandom, 16'd4, int'(A_ADDR_BYTES), -1);
    send_message(msg_q.size());
  endtask

  // every record kind, cut records and soa stops
  task automatic test_record_kinds();
    write_query_len(8'd0);
    msg_q.delete();
    add_header(16'h8180, 16'd7);
    add_record(TYPE_A, 32'h0000_0000, 16'h0004, int'(A_ADDR_BYTES), 0);
    add_record(TYPE_A, 32'hFFFF_FFFF, 16'hFFFF, int'(A_ADDR_BYTES), 255);
    add_record(TYPE_AAAA, 32'h0000_0000, 16'h0000, int'(AAAA_ADDR_BYTES), 0);
    add_record(TYPE_AAAA, 32'hFFFF_FFFF, 16'h0010, int'(AAAA_ADDR_BYTES), 255);
    add_record(TYPE_NS, $urandom, 16'd0, 0, -1);
    add_record(16'hFFFF, $urandom, 16'd10, 10, -1);
    add_record(TYPE_AAAA, $urandom, 16'($urandom), int'(AAAA_ADDR_BYTES), -1);
    // record closes on the final byte
    send_message(msg_q.size());
    // cut inside an address, then inside a fixed part
    send_message(QUESTION_FIXED_BYTES + 16 + 16 + 12 + 4);
    send_message(QUESTION_FIXED_BYTES + 16 + 7);
    // soa in the middle, trailing record ignored
    msg_q.delete();
    add_header(16'h8183, 16'd2);
    add_record(TYPE_A, $urandom, 16'd4, int'(A_ADDR_BYTES), -1);
    add_record(TYPE_SOA, $urandom, 16'd10, 10, -1);
    add_record(TYPE_A, $urandom, 16'd4, int'(A_ADDR_BYTES), -1);
    send_message(msg_q.size());
    // soa type completes on the final byte
    send_message(QUESTION_FIXED_BYTES + 16 + 4);
  endtask

  // question length changed while a message is half sent
  task automatic test_query_len_change();
    write_query_len(8'd40);
    msg_q.delete();
    add_header(16'($urandom), 16'($urandom));
    send_span(0, 25, 1'b0);
    // new start lies behind the position already reached
    write_query_len(8'd0);
    msg_q.delete();
    repeat (3) add_record(TYPE_A, $urandom, 16'($urandom), int'(A_ADDR_BYTES), -1);
    send_span(0, msg_q.size(), 1'b1);
    // new start lies ahead of the position
    msg_q.delete();
    add_header(16'($urandom), 16'($urandom));
    send_span(0, 10, 1'b0);
    write_query_len(8'd20);
    msg_q.delete();
    add_header(16'($urandom), 16'($urandom));
    add_record(TYPE_AAAA, $urandom, 16'($urandom), int'(AAAA_ADDR_BYTES), -1);
    send_span(10, msg_q.size(), 1'b1);
  endtask

  // receiver holds off while bytes keep coming, then sender waits for all
  task automatic test_backpressure();
    write_query_len(8'($urandom_range(24, 0)));
    src_gap_max = 0;
    sink_gap_max = 0;
    msg_q.delete();
    add_header(16'($urandom), 16'($urandom));
    repeat (6) add_record(TYPE_A, $urandom, 16'($urandom), int'(A_ADDR_BYTES), -1);
    repeat (2) add_record(TYPE_AAAA, $urandom, 16'($urandom), int'(AAAA_ADDR_BYTES), -1);
    hold_request = HOLD_CYCLES;
    send_message(msg_q.size());
    send_message(1);
    drain_results();
  endtask

  // one random message or noise burst, cut short at random or where the byte budget runs out
  task automatic send_random_message();
    int mode;
    int room;
    int len;
    room = ITEM_TARGET - sent_bytes;
    msg_q.delete();
    add_header(16'($urandom), 16'($urandom));
    repeat ($urandom_range(6, 0)) add_random_record();
    mode = $urandom_range(19, 0);
    if (mode < 3) begin
      // noise
      msg_q.delete();
      repeat ($urandom_range(60, 1)) add_byte(8'($urandom));
      len = msg_q.size();
    end else if (mode < 6) begin
      len = $urandom_range(msg_q.size(), 1);
    end else begin
      len = msg_q.size();
    end
    if (len > room)
      len = room;
    send_message(len);
  endtask

  // random messages in phases of question length and idling
  task automatic test_random_traffic();
    int pick;
    int batch;
    while (sent_bytes < ITEM_TARGET) begin
      pick = $urandom_range(19, 0);
      if (pick == 0)
        write_query_len(8'd253);
      else if (pick < 3)
        write_query_len(8'd0);
      else
        write_query_len(8'($urandom_range(24, 0)));
      src_gap_max = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
      sink_gap_max = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
      batch = $urandom_range(8, 2);
      for (int k = 0; k < batch && sent_bytes < ITEM_TARGET; k++)
        send_random_message();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    byte_ch.valid <= 1'b0;
    byte_ch.byte_value <= '0;
    byte_ch.last_byte <= 1'b0;
    qname_len_m = '0;
    clear_parse_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_messages();
    test_record_kinds();
    test_query_len_change();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
